// ===== design/lpvs_pkg.sv =====
// ----------------------------------------------------------------------------
// lpvs_pkg
// Shared widths, result codes and control types of the LRU page victim
// select unit.
// ----------------------------------------------------------------------------
package lpvs_pkg;

   // fixed field widths of the request and response beats
   localparam int PROC_W   = 4;
   localparam int PCNT_W   = 12;
   localparam int MASK_W   = 32;
   localparam int ACTION_W = 3;
   localparam int REF_W    = 5;
   localparam int TS_W     = 32;

   // default geometry
   localparam int DEF_NUM_PROCS      = 16;
   localparam int DEF_PAGES_PER_PROC = 32;
   localparam int DEF_PAGE_BYTES     = 128;

   // tick counter value after reset
   localparam logic [TS_W-1:0] TICK_INIT = TS_W'(1);

   // result codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_SKIP      = 3'd0,
      ACT_HIT       = 3'd1,
      ACT_PAGED_IN  = 3'd2,
      ACT_EVICT     = 3'd3,
      ACT_NO_VICTIM = 3'd4
   } action_type;

   // sequencer to oldest-timestamp tracker
   typedef struct packed {
      logic init;     // load tick as running minimum, clear found
      logic cmp_en;   // read data of one page is valid this cycle
   } trk_ctrl_type;

endpackage

// ===== design/lpvs_ts_ram.sv =====
// ----------------------------------------------------------------------------
// lpvs_ts_ram
// Last-use timestamp store, one entry per process and page. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module lpvs_ts_ram #(
   parameter int DEPTH  = lpvs_pkg::DEF_NUM_PROCS * lpvs_pkg::DEF_PAGES_PER_PROC,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = lpvs_pkg::TS_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   import lpvs_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lpvs_oldest_track.sv =====
// ----------------------------------------------------------------------------
// lpvs_oldest_track
// Shared compare unit of the victim scan: one timestamp per cycle against the
// running minimum, keeping the first resident page with the smallest value.
// ----------------------------------------------------------------------------
module lpvs_oldest_track #(
   parameter int PAGE_W = $clog2(lpvs_pkg::DEF_PAGES_PER_PROC)
) (
   input  logic                       clock,
   input  lpvs_pkg::trk_ctrl_type     ctrl,
   input  logic [lpvs_pkg::TS_W-1:0]  tick,
   input  logic [lpvs_pkg::TS_W-1:0]  stamp,
   input  logic                       resident,
   input  logic [PAGE_W-1:0]          page_idx,
   output logic                       found,
   output logic [PAGE_W-1:0]          victim
);
   import lpvs_pkg::*;

   logic [TS_W-1:0]   oldest_ff, oldest_in;
   logic              found_ff, found_in;
   logic [PAGE_W-1:0] victim_ff, victim_in;
   logic              older;

   // strict compare keeps the first page on ties
   assign older = resident && (stamp < oldest_ff);

   always_comb begin
      oldest_in = oldest_ff;
      found_in  = found_ff;
      victim_in = victim_ff;
      priority if (ctrl.init) begin
         oldest_in = tick;
         found_in  = 1'b0;
         victim_in = '0;
      end else if (ctrl.cmp_en && older) begin
         oldest_in = stamp;
         found_in  = 1'b1;
         victim_in = page_idx;
      end
   end

   always_ff @(posedge clock) begin
      oldest_ff <= oldest_in;
      found_ff  <= found_in;
      victim_ff <= victim_in;
   end

   assign found  = found_ff;
   assign victim = victim_ff;

endmodule

// ===== design/lpvs_seq.sv =====
// ----------------------------------------------------------------------------
// lpvs_seq
// Sequencer: timestamp store clear after reset, request decode, hit stamping,
// victim scan over the process's pages, tick counter and response register.
// ----------------------------------------------------------------------------
module lpvs_seq #(
   parameter int NUM_PROCS      = lpvs_pkg::DEF_NUM_PROCS,
   parameter int PAGES_PER_PROC = lpvs_pkg::DEF_PAGES_PER_PROC,
   parameter int PAGE_Q_W       = 6,
   parameter int PAGE_W         = $clog2(PAGES_PER_PROC),
   parameter int DEPTH          = NUM_PROCS * PAGES_PER_PROC,
   parameter int ADDR_W         = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request beat
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpvs_pkg::PROC_W-1:0]   req_proc_id,
   input  logic                          req_active,
   input  logic [PAGE_Q_W-1:0]           req_page,
   input  logic [lpvs_pkg::MASK_W-1:0]   req_resident_mask,
   input  logic                          req_pagein_ok,
   input  logic                          req_end_of_tick,
   // response beat
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpvs_pkg::ACTION_W-1:0] rsp_action,
   output logic [lpvs_pkg::REF_W-1:0]    rsp_ref_page,
   output logic [lpvs_pkg::REF_W-1:0]    rsp_victim_page,
   // timestamp store
   output logic                          ram_wr_en,
   output logic [ADDR_W-1:0]             ram_wr_addr,
   output logic [lpvs_pkg::TS_W-1:0]     ram_wr_data,
   output logic                          ram_rd_en,
   output logic [ADDR_W-1:0]             ram_rd_addr,
   // compare unit
   output lpvs_pkg::trk_ctrl_type        trk_ctrl,
   output logic [lpvs_pkg::TS_W-1:0]     trk_tick,
   output logic                          trk_resident,
   output logic [PAGE_W-1:0]             trk_page_idx,
   input  logic                          trk_found,
   input  logic [PAGE_W-1:0]             trk_victim
);
   import lpvs_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam int CNT_W = PAGE_W + 1;
   localparam int CLR_W = ADDR_W + 1;

   state_type                 state_ff, state_in;
   logic [CLR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [PROC_W-1:0]         proc_ff, proc_in;
   logic                      active_ff, active_in;
   logic [PAGE_Q_W-1:0]       page_ff, page_in;
   logic [PAGES_PER_PROC-1:0] mask_ff, mask_in;
   logic                      pin_ok_ff, pin_ok_in;
   logic                      eot_ff, eot_in;
   action_type                action_ff, action_in;
   logic [CNT_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                      cmp_pend_ff, cmp_pend_in;
   logic [PAGE_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [TS_W-1:0]           tick_ff, tick_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0]       rsp_action_ff, rsp_action_in;
   logic [REF_W-1:0]          rsp_ref_ff, rsp_ref_in;
   logic [REF_W-1:0]          rsp_victim_ff, rsp_victim_in;

   logic [PAGE_Q_W+REF_W-1:0] page_pad;
   logic [PAGE_W+REF_W-1:0]   victim_pad;
   logic [PAGE_W-1:0]         page_idx;
   logic [ADDR_W-1:0]         base_addr;
   logic                      ref_ok;
   logic                      scan_issue;
   logic                      rsp_free;

   // page index and base of this process's entries
   assign page_pad   = {REF_W'(0), page_ff};
   assign page_idx   = page_pad[PAGE_W-1:0];
   assign victim_pad = {REF_W'(0), trk_victim};
   assign base_addr  = ADDR_W'(32'(proc_ff) * PAGES_PER_PROC);
   assign ref_ok     = active_ff && (32'(proc_ff) < NUM_PROCS)
                       && (32'(page_ff) < PAGES_PER_PROC);
   assign scan_issue = (rd_cnt_ff < CNT_W'(PAGES_PER_PROC));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      proc_in       = proc_ff;
      active_in     = active_ff;
      page_in       = page_ff;
      mask_in       = mask_ff;
      pin_ok_in     = pin_ok_ff;
      eot_in        = eot_ff;
      action_in     = action_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_pend_in   = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      tick_in       = tick_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_action_in = rsp_action_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_victim_in = rsp_victim_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_cnt_ff[ADDR_W-1:0];
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ADDR_W'(32'(base_addr) + 32'(rd_cnt_ff));
      trk_ctrl      = '0;
      trk_ctrl.cmp_en = cmp_pend_ff;

      unique case (state_ff)
         // zero every timestamp once after reset
         ST_CLEAR: begin
            ram_wr_en  = 1'b1;
            clr_cnt_in = clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // capture the request beat
         ST_IDLE: begin
            if (req_valid) begin
               proc_in   = req_proc_id;
               active_in = req_active;
               page_in   = req_page;
               mask_in   = req_resident_mask[PAGES_PER_PROC-1:0];
               pin_ok_in = req_pagein_ok;
               eot_in    = req_end_of_tick;
               state_in  = ST_DECODE;
            end
         end
         // classify the reference
         ST_DECODE: begin
            priority if (!ref_ok) begin
               action_in = ACT_SKIP;
               state_in  = ST_DONE;
            end else if (mask_ff[page_idx]) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(32'(base_addr) + 32'(page_idx));
               ram_wr_data = tick_ff;
               action_in   = ACT_HIT;
               state_in    = ST_DONE;
            end else if (pin_ok_ff) begin
               action_in = ACT_PAGED_IN;
               state_in  = ST_DONE;
            end else begin
               trk_ctrl.init = 1'b1;
               rd_cnt_in     = '0;
               state_in      = ST_SCAN;
            end
         end
         // read one page a cycle, compare it in the next cycle
         ST_SCAN: begin
            if (scan_issue) begin
               ram_rd_en   = 1'b1;
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               cmp_pend_in = 1'b1;
               cmp_idx_in  = rd_cnt_ff[PAGE_W-1:0];
            end else if (!cmp_pend_ff) begin
               action_in = trk_found ? ACT_EVICT : ACT_NO_VICTIM;
               state_in  = ST_DONE;
            end
         end
         // hand over the result; advance the tick after an end-of-tick beat
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = action_ff;
               rsp_ref_in    = page_pad[REF_W-1:0];
               rsp_victim_in = (action_ff == ACT_EVICT) ? victim_pad[REF_W-1:0] : '0;
               if (eot_ff && (tick_ff != '1)) begin
                  tick_in = tick_ff + TS_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tick_ff      <= TICK_INIT;
         rsp_valid_ff <= 1'b0;
         cmp_pend_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         action_ff    <= ACT_SKIP;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_pend_ff  <= cmp_pend_in;
         rd_cnt_ff    <= rd_cnt_in;
         action_ff    <= action_in;
      end
      proc_ff       <= proc_in;
      active_ff     <= active_in;
      page_ff       <= page_in;
      mask_ff       <= mask_in;
      pin_ok_ff     <= pin_ok_in;
      eot_ff        <= eot_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_ref_page    = rsp_ref_ff;
   assign rsp_victim_page = rsp_victim_ff;
   assign trk_tick        = tick_ff;
   assign trk_resident    = mask_ff[cmp_idx_ff];
   assign trk_page_idx    = cmp_idx_ff;

   // no timestamp write while a scan reads the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_wr_en)
      else $error("timestamp write during victim scan");

   // tick counter never wraps to zero
   assert property (@(posedge clock) disable iff (reset)
      tick_ff != '0)
      else $error("tick counter reached zero");

   // a scan ends only after every page was read
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_SCAN && state_ff == ST_DONE)
      |-> (rd_cnt_ff == CNT_W'(PAGES_PER_PROC)))
      else $error("victim scan ended early");

   // a victim page is reported only with an eviction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff != ACT_EVICT) |-> (rsp_victim_ff == '0))
      else $error("victim page without eviction");

endmodule

// ===== design/lru_page_victim_select_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_victim_select_unit
// LRU page replacement with per-page last-use timestamps. After reset the
// unit zeroes every entry of its timestamp store and holds req_ready low
// meanwhile. It then takes one request beat at a time: a skipped reference,
// a hit or a successful page-in goes from decode straight to the response,
// and a miss with a failed page-in first scans all PAGES_PER_PROC pages of
// the process, reading one stored timestamp per cycle through the single
// read port into one shared comparator. A new request is accepted as soon
// as the unit is back in idle, even while the previous response beat is
// still waiting. The tick counter starts at 1, advances after a beat marked
// end_of_tick and saturates.
// ----------------------------------------------------------------------------
module lru_page_victim_select_unit #(
   parameter int NUM_PROCS      = lpvs_pkg::DEF_NUM_PROCS,
   parameter int PAGES_PER_PROC = lpvs_pkg::DEF_PAGES_PER_PROC,
   parameter int PAGE_BYTES     = lpvs_pkg::DEF_PAGE_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpvs_pkg::PROC_W-1:0]   req_proc_id,
   input  logic                          req_active,
   input  logic [lpvs_pkg::PCNT_W-1:0]   req_prog_counter,
   input  logic [lpvs_pkg::MASK_W-1:0]   req_resident_mask,
   input  logic                          req_pagein_ok,
   input  logic                          req_end_of_tick,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpvs_pkg::ACTION_W-1:0] rsp_action,
   output logic [lpvs_pkg::REF_W-1:0]    rsp_ref_page,
   output logic [lpvs_pkg::REF_W-1:0]    rsp_victim_page
);
   import lpvs_pkg::*;

   localparam int DEPTH      = NUM_PROCS * PAGES_PER_PROC;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int PAGE_W     = $clog2(PAGES_PER_PROC);
   // quotient width of program counter over page size
   localparam int PAGE_Q_W   = PCNT_W - $clog2(PAGE_BYTES) + 1;
   // exact reciprocal for any counter value below 2**PCNT_W
   localparam int PAGE_SHIFT = PCNT_W + $clog2(PAGE_BYTES);
   localparam int PAGE_RECIP = (2**PAGE_SHIFT + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int RECIP_W    = PCNT_W + 1;
   localparam int PROD_W     = PCNT_W + RECIP_W;

   logic [PROD_W-1:0]   page_prod;
   logic [PAGE_Q_W-1:0] req_page;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [TS_W-1:0]     ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [TS_W-1:0]     ram_rd_data;

   trk_ctrl_type        trk_ctrl;
   logic [TS_W-1:0]     trk_tick;
   logic                trk_resident;
   logic [PAGE_W-1:0]   trk_page_idx;
   logic                trk_found;
   logic [PAGE_W-1:0]   trk_victim;

   // page index by reciprocal multiply
   assign page_prod = PROD_W'(req_prog_counter) * PROD_W'(PAGE_RECIP);
   assign req_page  = PAGE_Q_W'(page_prod >> PAGE_SHIFT);

   lpvs_seq #(
      .NUM_PROCS      (NUM_PROCS),
      .PAGES_PER_PROC (PAGES_PER_PROC),
      .PAGE_Q_W       (PAGE_Q_W),
      .PAGE_W         (PAGE_W),
      .DEPTH          (DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_proc_id       (req_proc_id),
      .req_active        (req_active),
      .req_page          (req_page),
      .req_resident_mask (req_resident_mask),
      .req_pagein_ok     (req_pagein_ok),
      .req_end_of_tick   (req_end_of_tick),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_ref_page      (rsp_ref_page),
      .rsp_victim_page   (rsp_victim_page),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .trk_ctrl          (trk_ctrl),
      .trk_tick          (trk_tick),
      .trk_resident      (trk_resident),
      .trk_page_idx      (trk_page_idx),
      .trk_found         (trk_found),
      .trk_victim        (trk_victim)
   );

   lpvs_ts_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (TS_W)
   ) u_ts_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lpvs_oldest_track #(
      .PAGE_W (PAGE_W)
   ) u_oldest_track (
      .clock    (clock),
      .ctrl     (trk_ctrl),
      .tick     (trk_tick),
      .stamp    (ram_rd_data),
      .resident (trk_resident),
      .page_idx (trk_page_idx),
      .found    (trk_found),
      .victim   (trk_victim)
   );

endmodule
